>>> rtl/core/sha256_message_hasher_assert.svh
// Assertion macros for the SHA-256 message hasher checker.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH
// Assert that an implication holds on every clock edge outside reset.
`define SHM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that an implication holds in the cycle after the antecedent.
`define SHM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Constants, types and helper functions shared by the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam word_t K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // Datapath byte sources
  localparam logic [1:0] BSEL_DATA = 2'd0;
  localparam logic [1:0] BSEL_PAD  = 2'd1;
  localparam logic [1:0] BSEL_ZERO = 2'd2;
  localparam logic [1:0] BSEL_LEN  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic       put_byte;    // write one byte at the current position
    logic [1:0] byte_sel;
    logic       add_len;     // count a message byte
    logic       comp_start;  // load working vars from hash
    logic       round;       // run one round
    logic       comp_end;    // fold working vars into hash
    logic       clear;       // return to initial state
    logic       out_load;    // load digest word into output register
  } sha_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [5:0] byte_pos;
    logic [5:0] round_idx;
  } sha_sts_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/core/sha_stream_if.sv
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels of the SHA-256 hasher.
// ----------------------------------------------------------------------------
interface sha_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> rtl/core/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, rolling message schedule, round unit and hash registers.
// ----------------------------------------------------------------------------
module sha_datapath
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sha_cmd_t   cmd,
  input  logic [7:0] data_byte,
  input  logic [2:0] out_idx,
  output sha_sts_t   sts,
  output word_t      out_word
);

  word_t       w_r [16];
  word_t       v_r [8];
  word_t       h_r [8];
  logic [5:0]  pos_r;
  logic [5:0]  rnd_r;
  logic [63:0] len_r;
  word_t       out_r;

  logic [7:0]  byte_v;
  word_t       wt, s0, s1, t1, t2, wnew, e, a;
  logic [2:0]  lsel;

  assign lsel = pos_r[2:0];

  // Select the byte to store
  always_comb begin
    unique case (cmd.byte_sel)
      BSEL_DATA: byte_v = data_byte;
      BSEL_PAD:  byte_v = PAD_BYTE;
      BSEL_ZERO: byte_v = 8'h00;
      default:   byte_v = len_r[(7 - lsel) * 8 +: 8];
    endcase
  end

  // Round function over a 16-word sliding schedule
  always_comb begin
    wt   = w_r[0];
    s0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = s1 + w_r[9] + s0 + w_r[0];
    e    = v_r[4];
    a    = v_r[0];
    t1   = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & v_r[5]) ^ (~e & v_r[6])) + K_TABLE[rnd_r] + wt;
    t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // Block buffer and schedule shift
  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      w_r[pos_r[5:2]][(3 - pos_r[1:0]) * 8 +: 8] <= byte_v;
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wnew;
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
  end

  // Hash words, counters and length
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) h_r[i] <= H_INIT[i];
      pos_r <= '0;
      rnd_r <= '0;
      len_r <= '0;
    end else begin
      if (cmd.comp_end) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.put_byte) pos_r <= pos_r + 6'd1;
      if (cmd.add_len) len_r <= len_r + 64'd8;
      if (cmd.round) rnd_r <= rnd_r + 6'd1;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_r <= h_r[out_idx];
  end

  assign out_word     = out_r;
  assign sts.byte_pos  = pos_r;
  assign sts.round_idx = rnd_r;

endmodule

>>> rtl/core/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_has,
  input  logic       in_end,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_idx,
  output logic       hold_byte,
  input  sha_sts_t   sts,
  output sha_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;   // a message is being finished
  logic       padded_r, padded_nxt; // 0x80 already placed
  logic [2:0] idx_r, idx_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = idx_r;
  assign hold_byte = 1'b0;

  always_comb begin
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    padded_nxt = padded_r;
    idx_nxt    = idx_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_has) begin
            cmd.put_byte = 1'b1;
            cmd.byte_sel = BSEL_DATA;
            cmd.add_len  = 1'b1;
          end
          fin_nxt    = in_end;
          padded_nxt = 1'b0;
          if (in_has && sts.byte_pos == 6'd63) state_nxt = S_START;
          else if (in_end) state_nxt = S_PAD;
        end
      end
      S_START: begin
        cmd.comp_start = 1'b1;
        state_nxt      = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_idx == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.comp_end = 1'b1;
        if (!fin_r) state_nxt = S_IDLE;
        else if (padded_r && sts.byte_pos == 6'd0 && idx_r == 3'd1) begin
          state_nxt = S_LOAD;
          idx_nxt   = 3'd0;
        end else state_nxt = S_PAD;
      end
      S_PAD: begin
        // one byte per cycle: pad marker, zero fill, then length
        // idx_r is 2 while zero-filling an overflow block, 1 once the length is placed
        cmd.put_byte = 1'b1;
        if (!padded_r) begin
          cmd.byte_sel = BSEL_PAD;
          padded_nxt   = 1'b1;
          if (sts.byte_pos >= LEN_POS && sts.byte_pos != 6'd63) idx_nxt = 3'd2;
        end else if (idx_r == 3'd2 || sts.byte_pos < LEN_POS) cmd.byte_sel = BSEL_ZERO;
        else cmd.byte_sel = BSEL_LEN;
        if (sts.byte_pos == 6'd63) begin
          state_nxt = S_START;
          idx_nxt   = (cmd.byte_sel == BSEL_LEN) ? 3'd1 : 3'd0;
        end
      end
      S_LOAD: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (idx_r == 3'd7) begin
            cmd.clear = 1'b1;
            idx_nxt   = 3'd0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fin_r    <= 1'b0;
      padded_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      padded_r <= padded_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

>>> rtl/core/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// Byte-serial SHA-256 hasher with an eight-word digest stream.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | data_byte[7:0], has_byte, end_of_message
//  out_    | out | digest_word[31:0], word_index[2:0], last_word
//
// A byte that fills the block runs the shared round unit (load, 64 rounds,
// fold). Finishing writes the rest of the block one byte per cycle, runs
// one or two compressions, then sends eight registered digest words. Reset
// is synchronous and restores the initial hash. The input is stalled while
// a block or digest is in flight.
module sha256_message_hasher
  import sha_pkg::*;
(
  input logic clk,
  input logic rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_cmd_t   cmd;
  sha_sts_t   sts;
  logic [2:0] out_idx;
  logic       hold_byte;
  word_t      out_word;

  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_has    (in_ch.has_byte),
    .in_end    (in_ch.end_of_message),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_idx   (out_idx),
    .hold_byte (hold_byte),
    .sts       (sts),
    .cmd       (cmd)
  );

  sha_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_ch.data_byte ^ {8{hold_byte}}),
    .out_idx   (out_idx),
    .sts       (sts),
    .out_word  (out_word)
  );

  assign out_ch.digest_word = out_word;
  assign out_ch.word_index  = out_idx;
  assign out_ch.last_word   = (out_idx == 3'd7);

endmodule

>>> rtl/core/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the SHA-256 hasher, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_assert.svh"
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  `SHM_ASSERT_IMP(a_last_idx, clk, rst_n, out_valid, out_last_word == (out_word_index == 3'd7), "last_word mismatch")
  `SHM_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken during digest")
  `SHM_ASSERT_NXT(a_idx_step, clk, rst_n, out_valid && out_ready && !out_last_word, out_word_index == $past(out_word_index) + 3'd1, "word index skipped")
  `SHM_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_digest_word), "stalled word changed")

endmodule

bind sha256_message_hasher sha_checker u_sha_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_digest_word (out_ch.digest_word),
  .out_word_index  (out_ch.word_index),
  .out_last_word   (out_ch.last_word)
);

>>> sim/sha256_message_hasher_checker.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_checker
// Watches both channels of the hasher, predicts the digest words of every
// finished message and compares each word transfer against the prediction.
// ----------------------------------------------------------------------------
module sha256_message_hasher_checker
  import sha_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  sha_in_if      in_ch,
  sha_out_if     out_ch,
  output int     fail_count,
  output int     pending_words,
  output int     digests_seen
);

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  word_t        hash_state [8];
  word_t        block_buf [16];
  logic [5:0]   fill_pos;
  logic [63:0]  bit_len;
  digest_beat_t digest_queue [$];

  function automatic word_t ror(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run one compression of block_buf into hash_state
  task automatic compress_block();
    word_t w [64];
    word_t v [8];
    word_t t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic place_byte(logic [5:0] pos, logic [7:0] b);
    if (pos[1:0] == 2'd0) block_buf[pos[5:2]] = {b, 24'h0};
    else block_buf[pos[5:2]] |= word_t'(b) << (24 - 8 * pos[1:0]);
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
    fill_pos = '0;
    bit_len  = '0;
  endtask

  // Absorb one input transfer; queue the digest when the message ends
  task automatic absorb_item(logic [7:0] b, logic has_b, logic fin);
    digest_beat_t beat;
    logic [6:0] pos;
    if (has_b) begin
      place_byte(fill_pos, b);
      bit_len  += 64'd8;
      fill_pos += 6'd1;
      if (fill_pos == 6'd0) compress_block();
    end
    if (fin) begin
      place_byte(fill_pos, PAD_BYTE);
      pos = {1'b0, fill_pos} + 7'd1;
      if (pos > 7'd56) begin
        for (; pos < 7'd64; pos++) place_byte(pos[5:0], 8'h00);
        compress_block();
        pos = '0;
      end
      for (; pos < 7'd56; pos++) place_byte(pos[5:0], 8'h00);
      for (int j = 0; j < 8; j++) place_byte(LEN_POS + 6'(j), bit_len[63 - 8*j -: 8]);
      compress_block();
      for (int j = 0; j < 8; j++) begin
        beat.digest_word = hash_state[j];
        beat.word_index  = 3'(j);
        beat.last_word   = (j == 7);
        digest_queue.push_back(beat);
      end
      restart_message();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst_n) begin
      restart_message();
      digest_queue.delete();
      fail_count = 0;
      digests_seen <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        absorb_item(in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message);
      if (out_ch.valid && out_ch.ready) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("unexpected word", out_ch.digest_word, '0);
        end else begin
          want = digest_queue.pop_front();
          if (out_ch.digest_word !== want.digest_word)
            report_mismatch("digest_word", out_ch.digest_word, want.digest_word);
          if (out_ch.word_index !== want.word_index)
            report_mismatch("word_index", 32'(out_ch.word_index), 32'(want.word_index));
          if (out_ch.last_word !== want.last_word)
            report_mismatch("last_word", 32'(out_ch.last_word), 32'(want.last_word));
          if (want.last_word) digests_seen <= digests_seen + 1;
        end
      end
    end
    pending_words <= digest_queue.size();
  end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Byte-stream stimulus for the SHA-256 hasher: directed messages around
// the padding boundaries, then random messages with bursty input and
// stalling output, checked word by word by the companion checker.
// ----------------------------------------------------------------------------
module tb;
  import sha_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_words, digests_seen;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  int   stall_phase = 0;

  localparam int CYCLE_LIMIT = 1000000;

  sha_in_if  in_ch  (clk);
  sha_out_if out_ch (clk);

  sha256_message_hasher u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha256_message_hasher_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .digests_seen  (digests_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver stall pattern: runs of ready mixed with stretches of stalls
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 200 < 60) out_ch.ready <= 1'b1;
    else if (stall_phase % 200 < 120) out_ch.ready <= (stall_phase % 3 != 0);
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Send one item, with bursty gaps before it, and hold until transferred;
  // valid stays high into the next item of a burst and drops only for a gap
  task automatic send_item(logic [7:0] b, logic has_b, logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.has_byte       <= has_b;
    in_ch.end_of_message <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Message of len random or all-0xff bytes; the last byte may carry the end flag
  task automatic send_message(int len, bit fold_end, bit fixed_ff);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = fixed_ff ? 8'hff : 8'($urandom);
      send_item(b, 1'b1, fold_end && (i == len - 1));
    end
    if (!fold_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.has_byte       = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready         = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty message, noise item, extreme bytes, pad edges
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_message(3, 1'b1, 1'b1);
    send_message(55, 1'b1, 1'b0);
    send_message(56, 1'b0, 1'b0);
    send_message(63, 1'b1, 1'b0);
    send_message(64, 1'b0, 1'b1);
    send_message(65, 1'b1, 1'b0);

    // Random messages, mostly short, with some noise items mixed in
    while (items_sent < 460) begin
      if ($urandom_range(0, 9) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);
      else if ($urandom_range(0, 7) == 0 && items_sent < 330)
        send_message(int'($urandom_range(50, 130)), 1'($urandom_range(0, 1)), 1'b0);
      else
        send_message(int'($urandom_range(0, 12)), 1'($urandom_range(0, 1)), 1'b0);
    end
    in_ch.valid <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d input items; checked %0d digests of random and boundary-length messages.",
             items_sent, digests_seen);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
